// ===== sv/string_to_signed_long_parser_core_macros.svh =====
// assertion macros for the string to signed long parser
`ifndef STRING_TO_SIGNED_LONG_PARSER_CORE_MACROS_SVH
`define STRING_TO_SIGNED_LONG_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define STSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define STSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/stsl_pkg.sv =====
// shared types, constants and functions of the string to signed long parser
package stsl_pkg;

  localparam int unsigned MAX_LEN     = 4096;
  localparam int unsigned POS_W       = $clog2(MAX_LEN + 1);
  localparam int unsigned OFS_W       = 13;
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned BASE_W      = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned NO_DIGIT    = 36;
  localparam int unsigned MAX_RADIX   = 36;
  localparam int unsigned FIFO_DEPTH  = 2;

  localparam logic [BASE_W-1:0] RADIX_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_AUTO   = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_BAD    = BASE_W'(1);
  localparam logic [BASE_W-1:0] BASE_OCT    = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC    = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX    = BASE_W'(16);

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_BADBASE = 2'd2
  } status_e;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_ws;
    logic               is_sign;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               last;
    logic [BASE_W-1:0]  radix;
  } item_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_W'(NO_DIGIT);
    if (c >= CH_0 && c <= CH_9) begin
      d = DIGIT_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = DIGIT_W'(c - CH_LA + LETTER_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = DIGIT_W'(c - CH_UA + LETTER_OFS);
    end
    return d;
  endfunction

  function automatic logic base_invalid(input logic [BASE_W-1:0] b);
    return (b == BASE_BAD) || (b > BASE_W'(MAX_RADIX));
  endfunction

endpackage

// ===== sv/stsl_front.sv =====
// front end: radix register, input handshake and byte classification
module stsl_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [stsl_pkg::CHAR_W-1:0] char_code_i,
  input  logic                        last_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stsl_pkg::BASE_W-1:0] radix_i,
  input  logic                        full_i,
  output logic                        push_o,
  output stsl_pkg::item_t             item_o
);
  import stsl_pkg::*;

  logic [BASE_W-1:0] radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i) begin
      radix_q <= radix_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;

  always_comb begin
    item_o.digit    = digit_of(char_code_i);
    item_o.is_ws    = (char_code_i == CH_SPACE) ||
                      (char_code_i >= CH_TAB && char_code_i <= CH_CR);
    item_o.is_sign  = (char_code_i == CH_MINUS) || (char_code_i == CH_PLUS);
    item_o.is_minus = (char_code_i == CH_MINUS);
    item_o.is_zero  = (char_code_i == CH_0);
    item_o.is_x     = (char_code_i == CH_LX) || (char_code_i == CH_UX);
    item_o.last     = last_i;
    item_o.radix    = radix_q;
  end

endmodule

// ===== sv/stsl_fifo.sv =====
// short queue of classified bytes between front and back end
module stsl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  stsl_pkg::item_t wdata_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output stsl_pkg::item_t rdata_o
);
  import stsl_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== sv/stsl_back.sv =====
// back end: parse state machine, accumulator and result register
`include "string_to_signed_long_parser_core_macros.svh"

module stsl_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ent_valid_i,
  input  stsl_pkg::item_t                   ent_i,
  output logic                              ent_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [stsl_pkg::VAL_W-1:0] value_o,
  output logic [stsl_pkg::OFS_W-1:0]        end_offset_o,
  output logic [1:0]                        status_o
);
  import stsl_pkg::*;

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGN,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  localparam logic [VAL_W-1:0] LIMIT_POS = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] LIMIT_NEG = {1'b1, {(VAL_W-1){1'b0}}};
  localparam int unsigned PROD_W = VAL_W + BASE_W;

  phase_e             phase_q, phase_d, ph;
  logic               neg_q, neg_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  logic               ovf_q, ovf_d;
  logic [BASE_W-1:0]  base_q, base_d, base;
  logic [POS_W-1:0]   pos_q, pos_d, pos_n;
  logic [POS_W-1:0]   end_q, end_d;
  logic               out_valid_q, out_valid_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic [OFS_W-1:0]   ofs_q, ofs_d;
  status_e            status_q, status_d;

  logic               first, start, want, take, over, load;
  logic [VAL_W-1:0]   limit;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    sum;

  assign ent_pop_o = ent_valid_i && (!ent_i.last || !out_valid_q || out_ready_i);
  assign load      = ent_pop_o && ent_i.last;

  always_comb begin
    first = (pos_q == '0);
    base  = first ? ent_i.radix : base_q;
    ph    = (first && base_invalid(base)) ? PH_DONE : phase_q;
    pos_n = (pos_q < POS_W'(MAX_LEN)) ? pos_q + POS_W'(1) : pos_q;
    neg_d = neg_q;
    phase_d = ph;
    end_d = end_q;
    acc_d = acc_q;
    ovf_d = ovf_q;
    start = 1'b0;
    want  = 1'b0;

    case (ph)
      PH_WS: begin
        if (!ent_i.is_ws) begin
          if (ent_i.is_sign) begin
            neg_d   = ent_i.is_minus;
            phase_d = PH_SIGN;
          end else begin
            start = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (ent_i.is_x) begin
          base    = BASE_HEX;
          phase_d = PH_HEXPFX;
        end else begin
          if (base == BASE_AUTO) begin
            base = BASE_OCT;
          end
          want = 1'b1;
        end
      end
      PH_HEXPFX, PH_DIGITS: begin
        want = 1'b1;
      end
      default: begin
        want = 1'b0;
      end
    endcase

    if (start) begin
      if (ent_i.is_zero && (base == BASE_AUTO || base == BASE_HEX)) begin
        end_d   = pos_n;
        phase_d = PH_ZERO;
      end else begin
        if (base == BASE_AUTO) begin
          base = BASE_DEC;
        end
        want = 1'b1;
      end
    end

    take  = want && (ent_i.digit < base);
    limit = neg_q ? LIMIT_NEG : LIMIT_POS;
    prod  = PROD_W'(acc_q) * PROD_W'(base);
    sum   = (PROD_W + 1)'(prod) + (PROD_W + 1)'(ent_i.digit);
    over  = sum > (PROD_W + 1)'(limit);

    if (want) begin
      phase_d = take ? PH_DIGITS : PH_DONE;
    end
    if (take) begin
      end_d = pos_n;
      if (!ovf_q) begin
        if (over) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[VAL_W-1:0];
        end
      end
    end
    base_d = base;
    pos_d  = pos_n;

    if (base_invalid(base_d)) begin
      value_d  = '0;
      ofs_d    = '0;
      status_d = STAT_BADBASE;
    end else if (ovf_d) begin
      value_d  = limit;
      ofs_d    = OFS_W'(end_d);
      status_d = STAT_RANGE;
    end else begin
      value_d  = neg_q ? ('0 - acc_d) : acc_d;
      ofs_d    = OFS_W'(end_d);
      status_d = STAT_OK;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      base_q      <= BASE_AUTO;
      pos_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        phase_q <= PH_WS;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        base_q  <= BASE_AUTO;
        pos_q   <= '0;
        end_q   <= '0;
      end else if (ent_pop_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        base_q  <= base_d;
        pos_q   <= pos_d;
        end_q   <= end_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      value_q  <= value_d;
      ofs_q    <= ofs_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign end_offset_o = ofs_q;
  assign status_o     = status_q;

  `STSL_ASSERT_IMPL(a_no_overwrite, out_valid_q && !out_ready_i, !load,
    "result register overwritten while stalled")
  `STSL_ASSERT_NEXT(a_clear_after_last, load,
    pos_q == '0 && phase_q == PH_WS && !ovf_q && acc_q == '0,
    "parse state not cleared after last byte")
  `STSL_ASSERT_IMPL(a_acc_pos_range, !neg_q, !acc_q[VAL_W-1],
    "positive magnitude above maximum")
  `STSL_ASSERT_IMPL(a_end_within_pos, 1'b1, end_q <= pos_q,
    "end mark beyond bytes seen")

endmodule

// ===== sv/string_to_signed_long_parser_core.sv =====
// top level of the streaming string to signed 64-bit integer parser
// path: queue entry, then result register, from the accepted last byte to its result
// throughput: one byte per cycle while the queue is not full (combinational multiply-add)
// a stalled result register stops the queue only once the next last byte reaches its head
// reset: asynchronous active low, clears parse state, queue and result valid
// reset: radix returns to 10, no clearing pass, bytes accepted right after reset
module string_to_signed_long_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [stsl_pkg::CHAR_W-1:0]       char_code_i,
  input  logic                              last_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stsl_pkg::BASE_W-1:0]       radix_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [stsl_pkg::VAL_W-1:0] value_o,
  output logic [stsl_pkg::OFS_W-1:0]        end_offset_o,
  output logic [1:0]                        status_o
);
  import stsl_pkg::*;

  item_t push_item, pop_item;
  logic  push, pop, full, q_valid;

  stsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .radix_i     (radix_i),
    .full_i      (full),
    .push_o      (push),
    .item_o      (push_item)
  );

  stsl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (pop_item)
  );

  stsl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_valid_i  (q_valid),
    .ent_i        (pop_item),
    .ent_pop_o    (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .end_offset_o (end_offset_o),
    .status_o     (status_o)
  );

endmodule
